FILE: rtl/ipv4_dotted_quad_parser_macros.svh
// Assertion macros shared by the dotted-quad parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef IPV4_DOTTED_QUAD_PARSER_MACROS_SVH
`define IPV4_DOTTED_QUAD_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DQP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dqp assertion failed");

// Next-cycle implication, disabled during reset.
`define DQP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dqp assertion failed");

`endif

FILE: rtl/dqp_pkg.sv
// Shared types and constants of the dotted-quad IPv4 parser.
// Used by dqp_core, dqp_out_reg and the top level; depends on nothing.
`default_nettype none

package dqp_pkg;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [8:0] OCTET_LIMIT  = 9'd256;
   localparam logic [2:0] OCTETS_NORMAL = 3'd4;
   localparam logic [2:0] OCTETS_SUB    = 3'd3;

   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [7:0]  consumed;
      logic [2:0]  octet_count;
      logic        is_mask;
      logic        valid_res;
      logic [31:0] address;
   } res_type;

endpackage

`default_nettype wire

FILE: rtl/dqp_core.sv
// Parse state registers and the per-character next-state and result logic.
// Depends on dqp_pkg.
`default_nettype none

module dqp_core
   import dqp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_fire,
   input  wire logic       start_req,
   input  wire logic [7:0] char_code,
   output logic            res_valid,
   output res_type         res
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SPACE  = 2'd1;
   localparam logic [1:0] PH_SIGN   = 2'd2;
   localparam logic [1:0] PH_DIGITS = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [8:0]  value_ff, value_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  left_ff, left_in;
   logic [2:0]  done_ff, done_in;
   logic        neg_ff, neg_in;
   logic        sub_ff, sub_in;
   logic [7:0]  count_ff, count_in;

   logic [1:0]  eff_phase;
   logic [8:0]  eff_value;
   logic [31:0] eff_acc;
   logic [2:0]  eff_left;
   logic [2:0]  eff_done;
   logic        eff_neg;
   logic        eff_sub;
   logic [7:0]  eff_count;

   logic [7:0]  count_inc;
   logic [7:0]  digit;
   logic        is_digit;
   logic        is_space;
   logic        is_sign;
   logic [11:0] prod;
   logic [31:0] acc_shift;
   logic [2:0]  left_dec;
   logic [2:0]  done_inc;
   logic        fin;
   logic        fin_ok;
   logic [31:0] fin_acc;
   logic [2:0]  fin_done;
   logic [31:0] addr;
   logic [31:0] inv;

   always_comb begin
      eff_phase = phase_ff;
      eff_value = value_ff;
      eff_acc   = acc_ff;
      eff_left  = left_ff;
      eff_done  = done_ff;
      eff_neg   = neg_ff;
      eff_sub   = sub_ff;
      eff_count = count_ff;
      if (start_req) begin
         eff_phase = PH_SPACE;
         eff_value = '0;
         eff_acc   = '0;
         eff_left  = OCTETS_NORMAL;
         eff_done  = '0;
         eff_neg   = 1'b0;
         eff_sub   = 1'b0;
         eff_count = '0;
      end

      count_inc = (eff_count == 8'hFF) ? eff_count : eff_count + 8'd1;
      digit     = char_code - CHAR_ZERO;
      is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_space  = (char_code == CHAR_SPACE) ||
                  ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
      is_sign   = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);
      prod      = {eff_value, 3'b000} + {2'b00, eff_value, 1'b0} + {4'b0000, digit};
      acc_shift = {eff_acc[23:0], eff_value[7:0]};
      left_dec  = eff_left - 3'd1;
      done_inc  = eff_done + 3'd1;

      phase_in = eff_phase;
      value_in = eff_value;
      acc_in   = eff_acc;
      left_in  = eff_left;
      done_in  = eff_done;
      neg_in   = eff_neg;
      sub_in   = eff_sub;
      count_in = eff_count;
      fin      = 1'b0;
      fin_ok   = 1'b0;
      fin_acc  = eff_acc;
      fin_done = eff_done;

      if (start_req && (char_code == CHAR_DOT)) begin
         sub_in   = 1'b1;
         left_in  = OCTETS_SUB;
         count_in = count_inc;
      end else begin
         unique case (eff_phase)
            PH_IDLE: begin
            end
            PH_SPACE: begin
               if (is_space) begin
                  count_in = count_inc;
               end else if (is_sign) begin
                  neg_in   = (char_code == CHAR_MINUS);
                  phase_in = PH_SIGN;
                  count_in = count_inc;
               end else if (is_digit) begin
                  value_in = {1'b0, digit};
                  phase_in = PH_DIGITS;
                  count_in = count_inc;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_SIGN: begin
               if (is_digit) begin
                  value_in = {1'b0, digit};
                  phase_in = PH_DIGITS;
                  count_in = count_inc;
               end else begin
                  fin = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  value_in = (prod > {3'b000, OCTET_LIMIT}) ? OCTET_LIMIT : prod[8:0];
                  count_in = count_inc;
               end else if ((eff_value >= OCTET_LIMIT) ||
                            (eff_neg && (eff_value != 9'd0))) begin
                  fin = 1'b1;
               end else begin
                  acc_in   = acc_shift;
                  done_in  = done_inc;
                  left_in  = left_dec;
                  value_in = '0;
                  neg_in   = 1'b0;
                  fin_acc  = acc_shift;
                  fin_done = done_inc;
                  if (left_dec == 3'd0) begin
                     fin    = 1'b1;
                     fin_ok = 1'b1;
                  end else if (char_code == CHAR_DOT) begin
                     phase_in = PH_SPACE;
                     count_in = count_inc;
                  end else begin
                     fin    = 1'b1;
                     fin_ok = eff_sub;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (fin) begin
         phase_in = PH_IDLE;
      end

      addr            = fin_ok ? fin_acc : 32'd0;
      inv             = ~addr;
      res.address     = addr;
      res.valid_res   = fin_ok;
      res.is_mask     = fin_ok && !eff_sub && ((inv & (inv + 32'd1)) == 32'd0);
      res.octet_count = fin_done;
      res.consumed    = eff_count;
      res_valid       = item_fire && fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         value_ff <= '0;
         acc_ff   <= '0;
         left_ff  <= '0;
         done_ff  <= '0;
         neg_ff   <= 1'b0;
         sub_ff   <= 1'b0;
         count_ff <= '0;
      end else if (item_fire) begin
         phase_ff <= phase_in;
         value_ff <= value_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         done_ff  <= done_in;
         neg_ff   <= neg_in;
         sub_ff   <= sub_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dqp_out_reg.sv
// Result register that holds one finished result until the downstream takes it.
// Depends on dqp_pkg and ipv4_dotted_quad_parser_macros.svh.
`default_nettype none
`include "ipv4_dotted_quad_parser_macros.svh"

module dqp_out_reg
   import dqp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire res_type  res,
   output logic          can_load,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   output res_type       rsp_res
);

   logic    valid_ff, valid_in;
   res_type data_ff;

   assign can_load   = !valid_ff || rsp_tready;
   assign valid_in   = load || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_res    = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   `DQP_ASSERT_NOW(a_load_when_free, clock, reset, load, can_load)
   `DQP_ASSERT_NOW(a_valid_has_octet, clock, reset, valid_ff && data_ff.valid_res,
                   data_ff.octet_count != 3'd0)
   `DQP_ASSERT_NOW(a_mask_needs_valid, clock, reset, valid_ff && data_ff.is_mask,
                   data_ff.valid_res && (data_ff.octet_count == OCTETS_NORMAL))
   `DQP_ASSERT_NOW(a_reject_zero_addr, clock, reset, valid_ff && !data_ff.valid_res,
                   data_ff.address == 32'd0)
   `DQP_ASSERT_NEXT(a_held_result, clock, reset, valid_ff && !rsp_tready && !load,
                    valid_ff && $stable(data_ff))

endmodule

`default_nettype wire

FILE: rtl/ipv4_dotted_quad_parser.sv
// Dotted-decimal IPv4 address parser, top level. Depends on dqp_pkg, dqp_core
// and dqp_out_reg.
// Throughput: one character per cycle whenever the result register is free or drained.
// Output: the result is registered and appears on rsp in the cycle after its ending character is accepted.
// Reset: synchronous; the parser returns to idle and the result register empties.
`default_nettype none

module ipv4_dotted_quad_parser
   import dqp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // char_code
   input  wire logic                  req_tuser,  // start_req
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // address[31:0], valid_res[32], is_mask[33], octet_count[36:34],
   // consumed[44:37], zeros above
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic    item_fire;
   logic    res_valid;
   logic    can_load;
   res_type res;
   res_type rsp_res;

   assign req_tready = can_load;
   assign item_fire  = req_tvalid && req_tready;

   dqp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .start_req (req_tuser),
      .char_code (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   dqp_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {{(RSP_DATA_W - $bits(res_type)){1'b0}}, rsp_res};

endmodule

`default_nettype wire
